[hw/rtl/exact_k_distinct_window_counter_assert.svh]
// ----------------------------------------------------------------------------
// Assertion macros for the exact-k distinct window counter
// Clocked on clock, disabled while reset is high.
// ----------------------------------------------------------------------------
`ifndef EXACT_K_DISTINCT_WINDOW_COUNTER_ASSERT_SVH
`define EXACT_K_DISTINCT_WINDOW_COUNTER_ASSERT_SVH

// check a property at every clock edge
`define KDW_ASSERT(label, prop, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (prop)) else $error(msg);

// check that cons holds in the cycle after ante
`define KDW_ASSERT_NEXT(label, ante, cons, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) \
      else $error(msg);

`endif

[hw/rtl/kdw_pkg.sv]
// ----------------------------------------------------------------------------
// kdw_pkg
// Types and constants shared by the exact-k distinct window counter.
// ----------------------------------------------------------------------------
`default_nettype none

package kdw_pkg;

   localparam int VALUE_W     = 8;
   localparam int TOTAL_W     = 20;
   localparam int TARGET_W    = 9;
   localparam int EPOCH_W     = 8;
   localparam int QUEUE_DEPTH = 4;
   localparam int QUEUE_PTR_W = 2;

   typedef struct packed {
      logic [VALUE_W-1:0] value;
      logic               last;
   } req_type;

   typedef struct packed {
      logic [TOTAL_W-1:0] subarray_total;
      logic               done_res;
      logic               overflow;
   } rsp_type;

   typedef enum logic {
      KIND_STORE,
      KIND_DROP
   } kind_type;

   typedef struct packed {
      logic [VALUE_W-1:0] value;
      logic               last;
      kind_type           kind;
   } item_type;

   typedef struct packed {
      logic init_busy;
   } back_status_type;

   typedef enum logic [3:0] {
      ST_CLEAR,
      ST_IDLE,
      ST_ADD_RD,
      ST_ADD_WR,
      ST_CHECK,
      ST_SHR_RD,
      ST_SHR_WR,
      ST_FINISH
   } back_state_type;

endpackage

`default_nettype wire

[hw/rtl/kdw_front.sv]
// ----------------------------------------------------------------------------
// kdw_front
// Accepts request words, tags items past the length limit as drops.
// ----------------------------------------------------------------------------
`default_nettype none

module kdw_front #(
   parameter int MAX_LEN = 1024
) (
   input  logic                    clock,
   input  logic                    reset,
   input  logic                    req_valid,
   output logic                    req_ready,
   input  kdw_pkg::req_type        req_data,
   input  kdw_pkg::back_status_type back_status,
   input  logic                    q_full,
   output logic                    q_push,
   output kdw_pkg::item_type       q_item
);
   import kdw_pkg::*;

   localparam int PW = $clog2(MAX_LEN + 1);

   logic [PW-1:0] front_pos_ff, front_pos_in;
   logic          at_limit;

   assign req_ready = !q_full && !back_status.init_busy;
   assign q_push    = req_valid && req_ready;
   assign at_limit  = (front_pos_ff == PW'(MAX_LEN));

   always_comb begin
      q_item.value = req_data.value;
      q_item.last  = req_data.last;
      q_item.kind  = at_limit ? KIND_DROP : KIND_STORE;
      front_pos_in = front_pos_ff;
      if (q_push) begin
         if (req_data.last) begin
            front_pos_in = '0;
         end else if (!at_limit) begin
            front_pos_in = front_pos_ff + PW'(1);
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         front_pos_ff <= '0;
      end else begin
         front_pos_ff <= front_pos_in;
      end
   end

endmodule

`default_nettype wire

[hw/rtl/kdw_queue.sv]
// ----------------------------------------------------------------------------
// kdw_queue
// Short FIFO of classified items between the front and the back.
// ----------------------------------------------------------------------------
`default_nettype none

module kdw_queue (
   input  logic              clock,
   input  logic              reset,
   input  logic              push,
   input  kdw_pkg::item_type push_item,
   output logic              full,
   input  logic              pop,
   output kdw_pkg::item_type pop_item,
   output logic              empty
);
   import kdw_pkg::*;

   item_type               slots_ff [QUEUE_DEPTH];
   logic [QUEUE_PTR_W-1:0] wr_ptr_ff, wr_ptr_in;
   logic [QUEUE_PTR_W-1:0] rd_ptr_ff, rd_ptr_in;
   logic [QUEUE_PTR_W:0]   count_ff, count_in;
   logic                   do_push, do_pop;

   assign full     = (count_ff == (QUEUE_PTR_W + 1)'(QUEUE_DEPTH));
   assign empty    = (count_ff == '0);
   assign pop_item = slots_ff[rd_ptr_ff];
   assign do_push  = push && !full;
   assign do_pop   = pop && !empty;

   always_comb begin
      wr_ptr_in = do_push ? wr_ptr_ff + QUEUE_PTR_W'(1) : wr_ptr_ff;
      rd_ptr_in = do_pop ? rd_ptr_ff + QUEUE_PTR_W'(1) : rd_ptr_ff;
      count_in  = count_ff;
      if (do_push && !do_pop) begin
         count_in = count_ff + (QUEUE_PTR_W + 1)'(1);
      end else if (do_pop && !do_push) begin
         count_in = count_ff - (QUEUE_PTR_W + 1)'(1);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (do_push) begin
         slots_ff[wr_ptr_ff] <= push_item;
      end
   end

endmodule

`default_nettype wire

[hw/rtl/kdw_back.sv]
// ----------------------------------------------------------------------------
// kdw_back
// Runs the wide and narrow windows over the stored history, one item at a time.
// ----------------------------------------------------------------------------
`default_nettype none

`include "exact_k_distinct_window_counter_assert.svh"

module kdw_back #(
   parameter int VALUE_BITS = 8,
   parameter int MAX_LEN    = 1024
) (
   input  logic                            clock,
   input  logic                            reset,
   input  logic [kdw_pkg::TARGET_W-1:0]    target,
   input  logic                            q_empty,
   output logic                            q_pop,
   input  kdw_pkg::item_type               q_item,
   output kdw_pkg::back_status_type        back_status,
   output logic                            rsp_valid,
   input  logic                            rsp_ready,
   output kdw_pkg::rsp_type                rsp_data
);
   import kdw_pkg::*;

   localparam int PW        = $clog2(MAX_LEN + 1);
   localparam int HA_W      = $clog2(MAX_LEN);
   localparam int CA_W      = VALUE_BITS + 1;
   localparam int CNT_DEPTH = 2 << VALUE_BITS;
   localparam int CW        = PW;
   localparam int DW        = VALUE_BITS + 1;
   localparam int CMP_W     = (DW > TARGET_W) ? DW : TARGET_W;
   localparam int ENTRY_W   = EPOCH_W + CW;

   logic [VALUE_BITS-1:0] hist_mem [MAX_LEN];
   logic [ENTRY_W-1:0]    cnt_mem [CNT_DEPTH];
   logic [VALUE_BITS-1:0] hist_rd_ff;
   logic [ENTRY_W-1:0]    cnt_rd_ff;

   logic                  hist_we, hist_re;
   logic [HA_W-1:0]       hist_waddr, hist_raddr;
   logic [VALUE_BITS-1:0] hist_wdata;
   logic                  cnt_we, cnt_re;
   logic [CA_W-1:0]       cnt_waddr, cnt_raddr;
   logic [ENTRY_W-1:0]    cnt_wdata;

   back_state_type        state_ff, state_in;
   logic                  init_ff, init_in;
   logic [CA_W-1:0]       clr_addr_ff, clr_addr_in;
   logic [EPOCH_W-1:0]    epoch_ff, epoch_in;
   logic [VALUE_BITS-1:0] v_ff, v_in;
   logic                  last_ff, last_in;
   logic                  drop_ff, drop_in;
   logic                  sel_ff, sel_in;
   logic [DW-1:0]         wd_ff, wd_in, nd_ff, nd_in;
   logic [PW-1:0]         wl_ff, wl_in, nl_ff, nl_in;
   logic [PW-1:0]         pos_ff, pos_in;
   logic [TOTAL_W-1:0]    total_ff, total_in;
   logic                  ovf_ff, ovf_in;
   logic                  rsp_valid_ff, rsp_valid_in;
   rsp_type               rsp_data_ff, rsp_data_in;

   logic [PW-1:0]         end_pos, cur_left;
   logic [DW-1:0]         cur_distinct;
   logic [TARGET_W-1:0]   wide_bound, narrow_bound, cur_bound;
   logic                  shrink_go, out_free;
   logic [CW-1:0]         cur_count;
   logic [TOTAL_W-1:0]    total_next;
   logic                  ovf_next;

   assign back_status.init_busy = init_ff;
   assign rsp_valid             = rsp_valid_ff;
   assign rsp_data              = rsp_data_ff;

   assign end_pos      = pos_ff + PW'(1);
   assign cur_left     = sel_ff ? nl_ff : wl_ff;
   assign cur_distinct = sel_ff ? nd_ff : wd_ff;
   assign wide_bound   = target;
   assign narrow_bound = (target == '0) ? '0 : target - TARGET_W'(1);
   assign cur_bound    = sel_ff ? narrow_bound : wide_bound;
   assign shrink_go    = (CMP_W'(cur_distinct) > CMP_W'(cur_bound)) && (cur_left < end_pos);
   assign out_free     = !rsp_valid_ff || rsp_ready;
   assign cur_count    = (cnt_rd_ff[ENTRY_W-1:CW] == epoch_ff) ? cnt_rd_ff[CW-1:0] : '0;

   always_comb begin
      total_next = total_ff;
      if (!drop_ff && (nl_ff > wl_ff)) begin
         total_next = total_ff + TOTAL_W'(nl_ff - wl_ff);
      end
      ovf_next = ovf_ff || drop_ff;
   end

   always_comb begin
      state_in     = state_ff;
      init_in      = init_ff;
      clr_addr_in  = clr_addr_ff;
      epoch_in     = epoch_ff;
      v_in         = v_ff;
      last_in      = last_ff;
      drop_in      = drop_ff;
      sel_in       = sel_ff;
      wd_in        = wd_ff;
      nd_in        = nd_ff;
      wl_in        = wl_ff;
      nl_in        = nl_ff;
      pos_in       = pos_ff;
      total_in     = total_ff;
      ovf_in       = ovf_ff;
      rsp_valid_in = rsp_valid_ff && !rsp_ready;
      rsp_data_in  = rsp_data_ff;
      q_pop        = 1'b0;
      hist_we      = 1'b0;
      hist_waddr   = pos_ff[HA_W-1:0];
      hist_wdata   = v_ff;
      hist_re      = 1'b0;
      hist_raddr   = cur_left[HA_W-1:0];
      cnt_we       = 1'b0;
      cnt_waddr    = {sel_ff, v_ff};
      cnt_wdata    = {epoch_ff, cur_count};
      cnt_re       = 1'b0;
      cnt_raddr    = {sel_ff, v_ff};

      case (state_ff)
         ST_CLEAR: begin
            cnt_we      = 1'b1;
            cnt_waddr   = clr_addr_ff;
            cnt_wdata   = {epoch_ff, CW'(0)};
            clr_addr_in = clr_addr_ff + CA_W'(1);
            if (clr_addr_ff == '1) begin
               clr_addr_in = '0;
               init_in     = 1'b0;
               state_in    = ST_IDLE;
            end
         end
         ST_IDLE: begin
            if (!q_empty) begin
               q_pop   = 1'b1;
               v_in    = VALUE_BITS'(q_item.value);
               last_in = q_item.last;
               drop_in = (q_item.kind == KIND_DROP);
               sel_in  = 1'b0;
               if (q_item.kind == KIND_DROP) begin
                  state_in = ST_FINISH;
               end else begin
                  hist_we    = 1'b1;
                  hist_wdata = VALUE_BITS'(q_item.value);
                  state_in   = ST_ADD_RD;
               end
            end
         end
         ST_ADD_RD: begin
            cnt_re   = 1'b1;
            state_in = ST_ADD_WR;
         end
         ST_ADD_WR: begin
            cnt_we    = 1'b1;
            cnt_wdata = {epoch_ff, cur_count + CW'(1)};
            if (cur_count == '0) begin
               if (sel_ff) begin
                  nd_in = nd_ff + DW'(1);
               end else begin
                  wd_in = wd_ff + DW'(1);
               end
            end
            state_in = ST_CHECK;
         end
         ST_CHECK: begin
            if (shrink_go) begin
               hist_re  = 1'b1;
               state_in = ST_SHR_RD;
            end else if (!sel_ff) begin
               sel_in   = 1'b1;
               state_in = ST_ADD_RD;
            end else begin
               state_in = ST_FINISH;
            end
         end
         ST_SHR_RD: begin
            cnt_re    = 1'b1;
            cnt_raddr = {sel_ff, hist_rd_ff};
            state_in  = ST_SHR_WR;
         end
         ST_SHR_WR: begin
            cnt_waddr = {sel_ff, hist_rd_ff};
            cnt_wdata = {epoch_ff, cur_count - CW'(1)};
            if (cur_count != '0) begin
               cnt_we = 1'b1;
               if (cur_count == CW'(1)) begin
                  if (sel_ff) begin
                     nd_in = nd_ff - DW'(1);
                  end else begin
                     wd_in = wd_ff - DW'(1);
                  end
               end
            end
            if (sel_ff) begin
               nl_in = nl_ff + PW'(1);
            end else begin
               wl_in = wl_ff + PW'(1);
            end
            state_in = ST_CHECK;
         end
         ST_FINISH: begin
            if (out_free) begin
               rsp_valid_in                = 1'b1;
               rsp_data_in.subarray_total  = total_next;
               rsp_data_in.done_res        = last_ff;
               rsp_data_in.overflow        = ovf_next;
               if (last_ff) begin
                  wd_in    = '0;
                  nd_in    = '0;
                  wl_in    = '0;
                  nl_in    = '0;
                  pos_in   = '0;
                  total_in = '0;
                  ovf_in   = 1'b0;
                  epoch_in = epoch_ff + EPOCH_W'(1);
                  if (epoch_ff == '1) begin
                     clr_addr_in = '0;
                     state_in    = ST_CLEAR;
                  end else begin
                     state_in = ST_IDLE;
                  end
               end else begin
                  total_in = total_next;
                  ovf_in   = ovf_next;
                  pos_in   = drop_ff ? pos_ff : end_pos;
                  state_in = ST_IDLE;
               end
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_CLEAR;
         init_ff      <= 1'b1;
         clr_addr_ff  <= '0;
         epoch_ff     <= '0;
         sel_ff       <= 1'b0;
         wd_ff        <= '0;
         nd_ff        <= '0;
         wl_ff        <= '0;
         nl_ff        <= '0;
         pos_ff       <= '0;
         total_ff     <= '0;
         ovf_ff       <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         init_ff      <= init_in;
         clr_addr_ff  <= clr_addr_in;
         epoch_ff     <= epoch_in;
         sel_ff       <= sel_in;
         wd_ff        <= wd_in;
         nd_ff        <= nd_in;
         wl_ff        <= wl_in;
         nl_ff        <= nl_in;
         pos_ff       <= pos_in;
         total_ff     <= total_in;
         ovf_ff       <= ovf_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      v_ff        <= v_in;
      last_ff     <= last_in;
      drop_ff     <= drop_in;
      rsp_data_ff <= rsp_data_in;
   end

   always_ff @(posedge clock) begin
      if (hist_we) begin
         hist_mem[hist_waddr] <= hist_wdata;
      end
      if (hist_re) begin
         hist_rd_ff <= hist_mem[hist_raddr];
      end
   end

   always_ff @(posedge clock) begin
      if (cnt_we) begin
         cnt_mem[cnt_waddr] <= cnt_wdata;
      end
      if (cnt_re) begin
         cnt_rd_ff <= cnt_mem[cnt_raddr];
      end
   end

   `KDW_ASSERT(a_no_pop_in_clear, (state_ff == ST_CLEAR) |-> !q_pop, "item taken during clear pass")
   `KDW_ASSERT(a_window_bound, (state_ff == ST_FINISH && !drop_ff) |-> ((CMP_W'(wd_ff) <= CMP_W'(wide_bound)) && (CMP_W'(nd_ff) <= CMP_W'(narrow_bound))), "window over its distinct bound")
   `KDW_ASSERT_NEXT(a_left_hold, (state_ff != ST_SHR_WR && state_ff != ST_FINISH), (wl_ff == $past(wl_ff) && nl_ff == $past(nl_ff)), "left pointer moved outside a shrink step")

endmodule

`default_nettype wire

[hw/rtl/exact_k_distinct_window_counter.sv]
// ----------------------------------------------------------------------------
// exact_k_distinct_window_counter
// Running count of subarrays with exactly k distinct values, two sliding windows.
//
//   channel  dir  handshake            payload
//   req      in   req_valid/req_ready  req_data  (value, last)
//   rsp      out  rsp_valid/rsp_ready  rsp_data  (subarray_total, done_res, overflow)
//   csr      in   csr_valid/csr_ready  csr_data  (distinct_target)
//
// The back sequencer adds an item to the wide and then the narrow window, with a read
// and a write per left-pointer step of either; an item past MAX_LEN skips to the result.
// After reset all 2^(VALUE_BITS+1) count table entries are swept; req_ready is low.
// The sweep repeats after every 256th sequence; req keeps filling the 4-word queue.
// A stalled rsp holds the back at its result; req is taken until the queue fills.
// ----------------------------------------------------------------------------
`default_nettype none

module exact_k_distinct_window_counter #(
   parameter int VALUE_BITS = 8,
   parameter int MAX_LEN    = 1024
) (
   input  logic                         clock,
   input  logic                         reset,
   input  logic                         req_valid,
   output logic                         req_ready,
   input  kdw_pkg::req_type             req_data,
   output logic                         rsp_valid,
   input  logic                         rsp_ready,
   output kdw_pkg::rsp_type             rsp_data,
   input  logic                         csr_valid,
   output logic                         csr_ready,
   input  logic [kdw_pkg::TARGET_W-1:0] csr_data
);
   import kdw_pkg::*;

   logic [TARGET_W-1:0] target_ff, target_in;
   back_status_type     back_status;
   logic                q_full, q_empty, q_push, q_pop;
   item_type            q_push_item, q_pop_item;

   assign csr_ready = 1'b1;
   assign target_in = (csr_valid && csr_ready) ? csr_data : target_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         target_ff <= TARGET_W'(1);
      end else begin
         target_ff <= target_in;
      end
   end

   kdw_front #(
      .MAX_LEN (MAX_LEN)
   ) u_front (
      .clock       (clock),
      .reset       (reset),
      .req_valid   (req_valid),
      .req_ready   (req_ready),
      .req_data    (req_data),
      .back_status (back_status),
      .q_full      (q_full),
      .q_push      (q_push),
      .q_item      (q_push_item)
   );

   kdw_queue u_queue (
      .clock     (clock),
      .reset     (reset),
      .push      (q_push),
      .push_item (q_push_item),
      .full      (q_full),
      .pop       (q_pop),
      .pop_item  (q_pop_item),
      .empty     (q_empty)
   );

   kdw_back #(
      .VALUE_BITS (VALUE_BITS),
      .MAX_LEN    (MAX_LEN)
   ) u_back (
      .clock       (clock),
      .reset       (reset),
      .target      (target_ff),
      .q_empty     (q_empty),
      .q_pop       (q_pop),
      .q_item      (q_pop_item),
      .back_status (back_status),
      .rsp_valid   (rsp_valid),
      .rsp_ready   (rsp_ready),
      .rsp_data    (rsp_data)
   );

endmodule

`default_nettype wire

[tb/tb_exact_k_distinct_window_counter.sv]
// ----------------------------------------------------------------------------
// tb_exact_k_distinct_window_counter
// Self-checking bench for the exact-k distinct subarray counter. The bench
// tracks the wide and narrow sliding windows itself and predicts the running
// total for every accepted word. Each returned total is checked in order.
// Stimulus starts with directed sequences: value extremes, target zero, a
// target above the value range and a target change mid-sequence. Random
// sequences over small alphabets or the full value range follow, run under
// four idle and stall mixes with target rewrites between them.
// ----------------------------------------------------------------------------
module tb_exact_k_distinct_window_counter;
   timeunit 1ns;
   timeprecision 1ps;

   import kdw_pkg::*;

   localparam int VALUE_BITS = 8;
   localparam int MAX_LEN    = 1024;
   localparam int CLK_PERIOD = 8;
   localparam int GAP_CAP    = 20;
   localparam int PHASE_WORDS = 138;

   class exact_k_total_tracker;
      logic [TARGET_W-1:0] target;
      logic [VALUE_W-1:0]  history [MAX_LEN];
      int unsigned         counts [2][1 << VALUE_BITS];
      int unsigned         distinct [2];
      int unsigned         left_ptr [2];
      int unsigned         position;
      logic [TOTAL_W-1:0]  total;
      bit                  overflowed;
      rsp_type             totals_due [$];
      int                  errors;
      int                  checked;

      function new();
         target  = TARGET_W'(1);
         errors  = 0;
         checked = 0;
         clear_sequence();
      endfunction

      function void clear_sequence();
         foreach (counts[i, j]) counts[i][j] = 0;
         distinct   = '{0, 0};
         left_ptr   = '{0, 0};
         position   = 0;
         total      = '0;
         overflowed = 0;
      endfunction

      // add the newest value, then drop from the left until the bound holds
      function void slide(int win, int unsigned v, int unsigned stop_at, int unsigned bound);
         int unsigned old;
         if (counts[win][v] == 0) distinct[win]++;
         counts[win][v]++;
         while (distinct[win] > bound && left_ptr[win] < stop_at) begin
            old = history[left_ptr[win]];
            if (counts[win][old] > 0) begin
               counts[win][old]--;
               if (counts[win][old] == 0) distinct[win]--;
            end
            left_ptr[win]++;
         end
      endfunction

      function void note_word(req_type word);
         int unsigned stop_at;
         int unsigned wide_len;
         int unsigned narrow_len;
         rsp_type     due;
         if (position >= MAX_LEN) begin
            overflowed = 1;
         end else begin
            history[position] = word.value;
            stop_at = position + 1;
            slide(0, word.value, stop_at, target);
            slide(1, word.value, stop_at, (target == 0) ? 0 : target - 1);
            wide_len   = stop_at - left_ptr[0];
            narrow_len = stop_at - left_ptr[1];
            if (wide_len > narrow_len) total = TOTAL_W'(total + (wide_len - narrow_len));
            position = stop_at;
         end
         due.subarray_total = total;
         due.done_res       = word.last;
         due.overflow       = overflowed;
         totals_due.push_back(due);
         if (word.last) clear_sequence();
      endfunction

      function void check_word(rsp_type got);
         rsp_type due;
         checked++;
         if (totals_due.size() == 0) begin
            $error("unexpected result word: subarray_total %0d", got.subarray_total);
            errors++;
            return;
         end
         due = totals_due.pop_front();
         if (got.subarray_total !== due.subarray_total) begin
            $error("subarray_total: expected %0d, got %0d", due.subarray_total,
                   got.subarray_total);
            errors++;
         end
         if (got.done_res !== due.done_res) begin
            $error("done_res: expected %0b, got %0b", due.done_res, got.done_res);
            errors++;
         end
         if (got.overflow !== due.overflow) begin
            $error("overflow: expected %0b, got %0b", due.overflow, got.overflow);
            errors++;
         end
      endfunction
   endclass

   logic                clock;
   logic                reset;
   logic                req_valid;
   logic                req_ready;
   req_type             req_data;
   logic                rsp_valid;
   logic                rsp_ready;
   rsp_type             rsp_data;
   logic                csr_valid;
   logic                csr_ready;
   logic [TARGET_W-1:0] csr_data;

   int                  send_idle_pct;
   int                  stall_pct;
   int                  words_sent;
   int                  sequences;
   exact_k_total_tracker tracker;

   exact_k_distinct_window_counter #(
      .VALUE_BITS (VALUE_BITS),
      .MAX_LEN    (MAX_LEN)
   ) i_dut (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_ready (req_ready),
      .req_data  (req_data),
      .rsp_valid (rsp_valid),
      .rsp_ready (rsp_ready),
      .rsp_data  (rsp_data),
      .csr_valid (csr_valid),
      .csr_ready (csr_ready),
      .csr_data  (csr_data)
   );

   initial begin
      clock = 1'b0;
      forever #(CLK_PERIOD / 2) clock = ~clock;
   end

   task automatic push_word(input req_type word);
      int gap;
      gap = 0;
      while (gap < GAP_CAP && $urandom_range(99) < send_idle_pct) gap++;
      if (gap > 0) begin
         req_valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_valid <= 1'b1;
      req_data  <= word;
      do @(posedge clock); while (!req_ready);
      tracker.note_word(word);
      words_sent++;
   endtask

   task automatic send_value(input logic [VALUE_W-1:0] v, input logic last);
      req_type word;
      word.value = v;
      word.last  = last;
      push_word(word);
      if (last) sequences++;
   endtask

   // hold off the sender until every outstanding total has come back
   task automatic drain();
      req_valid <= 1'b0;
      while (tracker.totals_due.size() != 0) @(posedge clock);
      repeat (4) @(posedge clock);
   endtask

   task automatic write_target(input logic [TARGET_W-1:0] k);
      drain();
      csr_valid <= 1'b1;
      csr_data  <= k;
      do @(posedge clock); while (!csr_ready);
      csr_valid <= 1'b0;
      tracker.target = k;
   endtask

   function automatic logic [TARGET_W-1:0] pick_target();
      case ($urandom_range(9))
         0: return '0;
         1: return TARGET_W'(256);
         2: return TARGET_W'(255);
         3: return TARGET_W'($urandom_range(1, 256));
         default: return TARGET_W'($urandom_range(1, 5));
      endcase
   endfunction

   task automatic run_sequence(input int length, input bit close);
      logic [VALUE_W-1:0] alphabet [8];
      logic [VALUE_W-1:0] v;
      int                 span;
      bit                 full_range;
      span       = $urandom_range(1, 8);
      full_range = ($urandom_range(6) == 0);
      foreach (alphabet[i]) alphabet[i] = VALUE_W'($urandom_range(255));
      for (int i = 0; i < length; i++) begin
         v = full_range ? VALUE_W'($urandom_range(255)) : alphabet[$urandom_range(span - 1)];
         send_value(v, close && (i == length - 1));
      end
   endtask

   initial begin
      rsp_ready <= 1'b0;
      forever begin
         @(posedge clock);
         if (!reset && rsp_valid && rsp_ready) tracker.check_word(rsp_data);
         rsp_ready <= ($urandom_range(99) >= stall_pct);
      end
   end

   initial begin
      #(CLK_PERIOD * 600_000);
      $display("exact_k_distinct_window_counter test failed");
      $finish;
   end

   initial begin
      int send_pcts [4];
      int stall_pcts [4];
      int budget;
      int length;
      logic [VALUE_W-1:0] wide_set [8];

      send_pcts  = '{0, 56, 0, 38};
      stall_pcts = '{0, 0, 56, 38};
      wide_set   = '{8'h00, 8'hFF, 8'h55, 8'hAA, 8'h01, 8'h80, 8'h7F, 8'hFE};
      tracker       = new();
      send_idle_pct = 0;
      stall_pct     = 0;
      words_sent    = 0;
      sequences     = 0;
      reset     <= 1'b1;
      req_valid <= 1'b0;
      req_data  <= '0;
      csr_valid <= 1'b0;
      csr_data  <= '0;
      repeat (9) @(posedge clock);
      reset <= 1'b0;

      // reset target of one, value extremes
      send_value(8'h00, 1'b0);
      send_value(8'hFF, 1'b0);
      send_value(8'hFF, 1'b0);
      send_value(8'h00, 1'b0);
      send_value(8'h00, 1'b1);

      // target zero keeps both windows empty
      write_target('0);
      send_value(8'h03, 1'b0);
      send_value(8'h03, 1'b0);
      send_value(8'h07, 1'b1);

      // target above the value range: wide window never shrinks
      write_target(TARGET_W'(256));
      foreach (wide_set[i]) send_value(wide_set[i], i == 7);

      // change the target in the middle of a sequence
      write_target(TARGET_W'(2));
      send_value(8'h01, 1'b0);
      send_value(8'h02, 1'b0);
      send_value(8'h01, 1'b0);
      send_value(8'h03, 1'b0);
      send_value(8'h03, 1'b0);
      send_value(8'h02, 1'b0);
      write_target(TARGET_W'(1));
      send_value(8'h02, 1'b0);
      send_value(8'h02, 1'b0);
      send_value(8'h04, 1'b1);
      send_value(8'h09, 1'b1);

      for (int ph = 0; ph < 4; ph++) begin
         send_idle_pct = send_pcts[ph];
         stall_pct     = stall_pcts[ph];
         budget        = PHASE_WORDS;
         while (budget > 0) begin
            if ($urandom_range(1) == 1) write_target(pick_target());
            length = ($urandom_range(4) == 0) ? $urandom_range(25, 90) : $urandom_range(1, 24);
            if (length > budget) length = budget;
            run_sequence(length, $urandom_range(9) != 0);
            budget -= length;
         end
      end

      drain();
      repeat (20) @(posedge clock);
      $display("Checked %0d results from %0d words in %0d closed sequences.",
               tracker.checked, words_sent, sequences);
      $display("Targets 0 to 256 with mid-sequence changes under four idle and stall mixes.");
      if (tracker.errors == 0 && tracker.totals_due.size() == 0) begin
         $display("exact_k_distinct_window_counter test passed");
      end else begin
         $display("exact_k_distinct_window_counter test failed");
      end
      $finish;
   end

endmodule
